### sv/lnws_pkg.sv
// ----------------------------------------------------------------------------
// lnws_pkg
// Shared types, codes and constants of the four-bit LCD write sequencer.
// ----------------------------------------------------------------------------
package lnws_pkg;

  // Configuration port geometry: six 16-bit registers at byte addresses 4*i.
  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned HOLD_W   = 16;

  // Register indexes.
  localparam logic [2:0] REG_SETUP_HOLD  = 3'd0;
  localparam logic [2:0] REG_ENABLE_HOLD = 3'd1;
  localparam logic [2:0] REG_NIBBLE_GAP  = 3'd2;
  localparam logic [2:0] REG_BYTE_DONE   = 3'd3;
  localparam logic [2:0] REG_POWER_UP    = 3'd4;
  localparam logic [2:0] REG_INIT_GAP    = 3'd5;

  // Register reset values.
  localparam logic [HOLD_W-1:0] RST_SETUP_HOLD  = 16'd1;
  localparam logic [HOLD_W-1:0] RST_ENABLE_HOLD = 16'd1000;
  localparam logic [HOLD_W-1:0] RST_NIBBLE_GAP  = 16'd200;
  localparam logic [HOLD_W-1:0] RST_BYTE_DONE   = 16'd2000;
  localparam logic [HOLD_W-1:0] RST_POWER_UP    = 16'd35000;
  localparam logic [HOLD_W-1:0] RST_INIT_GAP    = 16'd1000;

  // Display command constants.
  localparam logic [7:0] CMD_CURSOR_ROW0 = 8'h80;
  localparam logic [7:0] CMD_CURSOR_ROW1 = 8'hC0;
  localparam logic [3:0] NIB_WAKE        = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT    = 4'h2;
  localparam logic [3:0] MAX_COLUMN      = 4'hF;

  // Init sequence bookkeeping.
  localparam logic [1:0] LAST_WAKE_NIB   = 2'd2;
  localparam logic [2:0] LAST_INIT_BYTE  = 3'd4;
  localparam logic [2:0] PHASE_LONE_LAST = 3'd2;
  localparam logic [2:0] PHASE_BYTE_LAST = 3'd5;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_BYTE   = 2'd1,
    OP_NIBBLE = 2'd2,
    OP_CURSOR = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POWER,
    ST_LONE,
    ST_BYTE,
    ST_REJECT
  } state_t;

  // Source of the nibble placed on D7..D4.
  typedef enum logic [2:0] {
    NIB_BUS,
    NIB_THREE,
    NIB_TWO,
    NIB_VALUE_HI,
    NIB_BYTE_HI,
    NIB_BYTE_LO
  } nib_sel_t;

  // Source of the hold time.
  typedef enum logic [2:0] {
    HOLD_ZERO,
    HOLD_SETUP,
    HOLD_ENABLE,
    HOLD_GAP,
    HOLD_DONE,
    HOLD_POWER,
    HOLD_INIT_GAP
  } hold_sel_t;

  typedef struct packed {
    logic [HOLD_W-1:0] setup_hold_us;
    logic [HOLD_W-1:0] enable_hold_us;
    logic [HOLD_W-1:0] nibble_gap_us;
    logic [HOLD_W-1:0] byte_done_us;
    logic [HOLD_W-1:0] power_up_us;
    logic [HOLD_W-1:0] init_gap_us;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic      load;
    logic      emit;
    nib_sel_t  nib_sel;
    hold_sel_t hold_sel;
    logic      enable;
    logic      last;
    logic      rejected;
    logic      from_table;
    logic [2:0] table_idx;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic cursor_bad;
  } status_t;

  // Command bytes sent after the wake-up nibbles.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h80;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h0C;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

endpackage

### sv/lnws_regs.sv
// ----------------------------------------------------------------------------
// lnws_regs
// APB-style register file holding the six timing registers.
// ----------------------------------------------------------------------------
module lnws_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lnws_pkg::ADDR_W-1:0]  paddr,
  input  logic [lnws_pkg::DATA_W-1:0]  pwdata,
  output logic [lnws_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output lnws_pkg::cfg_t               cfg
);

  logic [2:0]                  reg_idx;
  logic                        wr_en;
  logic [lnws_pkg::HOLD_W-1:0] wdata;
  logic [lnws_pkg::HOLD_W-1:0] rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lnws_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign wdata   = pwdata[lnws_pkg::HOLD_W-1:0];

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_hold_us  <= lnws_pkg::RST_SETUP_HOLD;
      cfg.enable_hold_us <= lnws_pkg::RST_ENABLE_HOLD;
      cfg.nibble_gap_us  <= lnws_pkg::RST_NIBBLE_GAP;
      cfg.byte_done_us   <= lnws_pkg::RST_BYTE_DONE;
      cfg.power_up_us    <= lnws_pkg::RST_POWER_UP;
      cfg.init_gap_us    <= lnws_pkg::RST_INIT_GAP;
    end else if (wr_en) begin
      case (reg_idx)
        lnws_pkg::REG_SETUP_HOLD:  cfg.setup_hold_us  <= wdata;
        lnws_pkg::REG_ENABLE_HOLD: cfg.enable_hold_us <= wdata;
        lnws_pkg::REG_NIBBLE_GAP:  cfg.nibble_gap_us  <= wdata;
        lnws_pkg::REG_BYTE_DONE:   cfg.byte_done_us   <= wdata;
        lnws_pkg::REG_POWER_UP:    cfg.power_up_us    <= wdata;
        lnws_pkg::REG_INIT_GAP:    cfg.init_gap_us    <= wdata;
        default: ;
      endcase
    end
  end

  // Read mux; unknown indexes read as zero.
  always_comb begin
    case (reg_idx)
      lnws_pkg::REG_SETUP_HOLD:  rdata = cfg.setup_hold_us;
      lnws_pkg::REG_ENABLE_HOLD: rdata = cfg.enable_hold_us;
      lnws_pkg::REG_NIBBLE_GAP:  rdata = cfg.nibble_gap_us;
      lnws_pkg::REG_BYTE_DONE:   rdata = cfg.byte_done_us;
      lnws_pkg::REG_POWER_UP:    rdata = cfg.power_up_us;
      lnws_pkg::REG_INIT_GAP:    rdata = cfg.init_gap_us;
      default:                   rdata = '0;
    endcase
  end

  assign prdata = {{(lnws_pkg::DATA_W-lnws_pkg::HOLD_W){1'b0}}, rdata};

endmodule

### sv/lnws_ctrl.sv
// ----------------------------------------------------------------------------
// lnws_ctrl
// Sequencer state machine: walks the pin-state steps of each operation.
// ----------------------------------------------------------------------------
module lnws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  lnws_pkg::status_t status,
  output lnws_pkg::cmd_t    cmd
);

  lnws_pkg::state_t  state, state_next;
  logic [2:0]        phase, phase_next;
  logic              init_mode, init_mode_next;
  logic [1:0]        nib_cnt, nib_cnt_next;
  logic [2:0]        byte_idx, byte_idx_next;
  lnws_pkg::opcode_t op;

  assign op = lnws_pkg::opcode_t'(opcode);

  // State and step counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lnws_pkg::ST_IDLE;
      phase     <= '0;
      init_mode <= 1'b0;
      nib_cnt   <= '0;
      byte_idx  <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      init_mode <= init_mode_next;
      nib_cnt   <= nib_cnt_next;
      byte_idx  <= byte_idx_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    init_mode_next = init_mode;
    nib_cnt_next   = nib_cnt;
    byte_idx_next  = byte_idx;
    in_stall       = (state != lnws_pkg::ST_IDLE);
    cmd            = '0;
    cmd.nib_sel    = lnws_pkg::NIB_BUS;
    cmd.hold_sel   = lnws_pkg::HOLD_ZERO;
    cmd.from_table = init_mode;
    cmd.table_idx  = byte_idx;

    unique case (state)
      lnws_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          phase_next     = '0;
          init_mode_next = 1'b0;
          nib_cnt_next   = '0;
          byte_idx_next  = '0;
          unique case (op)
            lnws_pkg::OP_INIT: begin
              init_mode_next = 1'b1;
              state_next     = lnws_pkg::ST_POWER;
            end
            lnws_pkg::OP_BYTE:   state_next = lnws_pkg::ST_BYTE;
            lnws_pkg::OP_NIBBLE: state_next = lnws_pkg::ST_LONE;
            lnws_pkg::OP_CURSOR: begin
              state_next = status.cursor_bad ? lnws_pkg::ST_REJECT : lnws_pkg::ST_BYTE;
            end
          endcase
        end
      end

      // Power-up wait with D7..D4 left as they were.
      lnws_pkg::ST_POWER: begin
        cmd.emit     = 1'b1;
        cmd.hold_sel = lnws_pkg::HOLD_POWER;
        if (status.out_free) begin
          state_next = lnws_pkg::ST_LONE;
          phase_next = '0;
        end
      end

      // Lone nibble: place, strobe, release.
      lnws_pkg::ST_LONE: begin
        cmd.emit = 1'b1;
        if (init_mode) begin
          cmd.nib_sel = (nib_cnt == lnws_pkg::LAST_WAKE_NIB) ? lnws_pkg::NIB_TWO
                                                             : lnws_pkg::NIB_THREE;
        end else begin
          cmd.nib_sel = lnws_pkg::NIB_VALUE_HI;
        end
        cmd.enable = (phase == 3'd1);
        unique case (phase)
          3'd0:    cmd.hold_sel = lnws_pkg::HOLD_SETUP;
          3'd1:    cmd.hold_sel = lnws_pkg::HOLD_ENABLE;
          default: begin
            cmd.hold_sel = (init_mode && nib_cnt != lnws_pkg::LAST_WAKE_NIB)
                           ? lnws_pkg::HOLD_INIT_GAP : lnws_pkg::HOLD_ZERO;
          end
        endcase
        cmd.last = (phase == lnws_pkg::PHASE_LONE_LAST) && !init_mode;
        if (status.out_free) begin
          if (phase != lnws_pkg::PHASE_LONE_LAST) begin
            phase_next = phase + 3'd1;
          end else if (!init_mode) begin
            state_next = lnws_pkg::ST_IDLE;
          end else if (nib_cnt == lnws_pkg::LAST_WAKE_NIB) begin
            state_next    = lnws_pkg::ST_BYTE;
            phase_next    = '0;
            byte_idx_next = '0;
          end else begin
            nib_cnt_next = nib_cnt + 2'd1;
            phase_next   = '0;
          end
        end
      end

      // Full byte: high nibble then low nibble, each strobed.
      lnws_pkg::ST_BYTE: begin
        cmd.emit    = 1'b1;
        cmd.nib_sel = (phase < 3'd3) ? lnws_pkg::NIB_BYTE_HI : lnws_pkg::NIB_BYTE_LO;
        cmd.enable  = (phase == 3'd1) || (phase == 3'd4);
        unique case (phase)
          3'd1, 3'd4: cmd.hold_sel = lnws_pkg::HOLD_ENABLE;
          3'd2:       cmd.hold_sel = lnws_pkg::HOLD_GAP;
          3'd5:       cmd.hold_sel = lnws_pkg::HOLD_DONE;
          default:    cmd.hold_sel = lnws_pkg::HOLD_ZERO;
        endcase
        cmd.last = (phase == lnws_pkg::PHASE_BYTE_LAST)
                   && (!init_mode || byte_idx == lnws_pkg::LAST_INIT_BYTE);
        if (status.out_free) begin
          if (phase != lnws_pkg::PHASE_BYTE_LAST) begin
            phase_next = phase + 3'd1;
          end else if (cmd.last) begin
            state_next = lnws_pkg::ST_IDLE;
          end else begin
            byte_idx_next = byte_idx + 3'd1;
            phase_next    = '0;
          end
        end
      end

      // Refused cursor position: one flagged beat, pins unchanged.
      lnws_pkg::ST_REJECT: begin
        cmd.emit     = 1'b1;
        cmd.rejected = 1'b1;
        cmd.last     = 1'b1;
        if (status.out_free) begin
          state_next = lnws_pkg::ST_IDLE;
        end
      end

      default: state_next = lnws_pkg::ST_IDLE;
    endcase
  end

endmodule

### sv/lnws_dp.sv
// ----------------------------------------------------------------------------
// lnws_dp
// Datapath: operand latch, pin-state muxes, bus state and output register.
// ----------------------------------------------------------------------------
module lnws_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  lnws_pkg::cfg_t              cfg,
  input  lnws_pkg::cmd_t              cmd,
  output lnws_pkg::status_t           status,
  input  logic [1:0]                  opcode,
  input  logic                        select_data,
  input  logic [7:0]                  value,
  input  logic [1:0]                  row,
  input  logic [5:0]                  column,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  data_nibble,
  output logic                        select_pin,
  output logic                        enable_pin,
  output logic [lnws_pkg::HOLD_W-1:0] hold_us,
  output logic                        rejected,
  output logic                        last
);

  lnws_pkg::opcode_t           op;
  logic [7:0]                  byte_reg;
  logic                        rs_reg;
  logic [3:0]                  bus_nibble;
  logic                        select_level;
  logic [7:0]                  cur_byte;
  logic [3:0]                  nib;
  logic                        sel;
  logic [lnws_pkg::HOLD_W-1:0] hold;
  logic                        fire;

  assign op = lnws_pkg::opcode_t'(opcode);

  // Status back to the controller.
  assign status.out_free   = !out_valid || !out_stall;
  assign status.cursor_bad = (row > 2'd1) || (column > {2'b00, lnws_pkg::MAX_COLUMN});

  // Operand latch: byte to send and register select for this operation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (op == lnws_pkg::OP_CURSOR) begin
        byte_reg <= (row[0] ? lnws_pkg::CMD_CURSOR_ROW1 : lnws_pkg::CMD_CURSOR_ROW0)
                    | {4'h0, column[3:0]};
      end else begin
        byte_reg <= value;
      end
      rs_reg <= ((op == lnws_pkg::OP_BYTE) || (op == lnws_pkg::OP_NIBBLE)) && select_data;
    end
  end

  assign cur_byte = cmd.from_table ? lnws_pkg::init_byte(cmd.table_idx) : byte_reg;

  // Nibble selection.
  always_comb begin
    unique case (cmd.nib_sel)
      lnws_pkg::NIB_THREE:    nib = lnws_pkg::NIB_WAKE;
      lnws_pkg::NIB_TWO:      nib = lnws_pkg::NIB_FOUR_BIT;
      lnws_pkg::NIB_VALUE_HI: nib = byte_reg[7:4];
      lnws_pkg::NIB_BYTE_HI:  nib = cur_byte[7:4];
      lnws_pkg::NIB_BYTE_LO:  nib = cur_byte[3:0];
      default:                nib = bus_nibble;
    endcase
  end

  // Hold time selection.
  always_comb begin
    unique case (cmd.hold_sel)
      lnws_pkg::HOLD_SETUP:    hold = cfg.setup_hold_us;
      lnws_pkg::HOLD_ENABLE:   hold = cfg.enable_hold_us;
      lnws_pkg::HOLD_GAP:      hold = cfg.nibble_gap_us;
      lnws_pkg::HOLD_DONE:     hold = cfg.byte_done_us;
      lnws_pkg::HOLD_POWER:    hold = cfg.power_up_us;
      lnws_pkg::HOLD_INIT_GAP: hold = cfg.init_gap_us;
      default:                 hold = '0;
    endcase
  end

  assign sel  = cmd.rejected ? select_level : rs_reg;
  assign fire = cmd.emit && status.out_free;

  // Output register valid flag and the pin levels left on the bus.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      bus_nibble   <= '0;
      select_level <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        if (!cmd.rejected) begin
          bus_nibble   <= nib;
          select_level <= sel;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      data_nibble <= nib;
      select_pin  <= sel;
      enable_pin  <= cmd.enable;
      hold_us     <= hold;
      rejected    <= cmd.rejected;
      last        <= cmd.last;
    end
  end

endmodule

### sv/lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_nibble_write_sequencer
// Four-bit character LCD bus sequencer with timing registers.
// ----------------------------------------------------------------------------
// Each accepted operation is turned into a run of output beats, one pin state
// of the display bus (D7..D4, register select, enable) plus the time in
// microseconds it must be held; the final beat of a run carries last. The
// block takes one operation at a time: the input is accepted only while the
// sequencer is idle, then one beat is produced per cycle whenever the output
// register is free. A byte write or cursor move is 6 beats, a lone nibble 3,
// a refused cursor 1 and init 40; the step walk of the controller sets
// these figures. Timing registers sit on the APB port at byte addresses
// 0x00 to 0x14 and should be written only while the block is idle.
module lcd_nibble_write_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lnws_pkg::ADDR_W-1:0]  paddr,
  input  logic [lnws_pkg::DATA_W-1:0]  pwdata,
  output logic [lnws_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // Operation input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   opcode,
  input  logic                         select_data,
  input  logic [7:0]                   value,
  input  logic [1:0]                   row,
  input  logic [5:0]                   column,
  // Pin-state output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3:0]                   data_nibble,
  output logic                         select_pin,
  output logic                         enable_pin,
  output logic [lnws_pkg::HOLD_W-1:0]  hold_us,
  output logic                         rejected,
  output logic                         last
);

  lnws_pkg::cfg_t    cfg;
  lnws_pkg::cmd_t    cmd;
  lnws_pkg::status_t status;

  // Timing registers.
  lnws_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Step sequencer.
  lnws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  // Pin-state datapath.
  lnws_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .opcode      (opcode),
    .select_data (select_data),
    .value       (value),
    .row         (row),
    .column      (column),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_nibble (data_nibble),
    .select_pin  (select_pin),
    .enable_pin  (enable_pin),
    .hold_us     (hold_us),
    .rejected    (rejected),
    .last        (last)
  );

endmodule
